// File: rtl/msg_pkg.sv
// Shared widths, status codes and control struct for the colour gradient block.
// No dependencies; every other rtl file refers to it by scoped names.
package msg_pkg;

  localparam int IDX_W          = 8;   // palette index
  localparam int LEN_W          = 9;   // gradient length and segment offsets
  localparam int CNT_W          = 3;   // colour count and segment count
  localparam int CH_W           = 8;   // one colour channel
  localparam int NUM_CH         = 3;
  localparam int COLOR_W        = CH_W * NUM_CH;
  localparam int NUM_W          = CH_W + LEN_W;   // weighted sum before the divide
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = COLOR_W;
  localparam int LUT_DEPTH      = 256;
  localparam int MAX_COLORS_DEF = 6;
  localparam int DIV_STEP       = 2;              // quotient bits per divider stage
  localparam int DIV_STAGES     = CH_W / DIV_STEP;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_LUT_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_0     = 3'd2;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    pass_end;   // segment of one entry: answer is its end colour
  } item_ctl_t;

endpackage

// File: rtl/multi_stop_color_gradient.sv
// Multi-stop colour gradient lookup: palette index in, interpolated RGB out.
// Holds the configuration registers and the valid/stall chain; uses msg_pkg,
// msg_seg, msg_lerp and msg_div.
//
// Usage
//   in_*  : one palette index per request in in_tdata[7:0].
//   out_* : red, green, blue in out_tdata[7:0], [15:8], [23:16]; status in
//           out_tuser (0 ok, 1 index not below lut_size, 2 lut_size smaller
//           than the segment count, colours then zero).
//   cfg_* : write lut_size (0), color_count (1), color_0..color_5 (2..7) while
//           no request is in flight.
// Throughput is one request per cycle while the output is not stalled; nine
// register stages: the four segment stages, the weighting multiply and the
// four divider stages (two quotient bits each).
// Every stage has its own valid bit and moves when the stage after it is empty
// or moving, so empty slots are filled while out_tready is low and the block
// keeps accepting until all nine stages hold requests. A stall loses nothing.
// Reset empties the pipeline and loads lut_size 256, color_count 2, color_1
// white and the other colours black.
module multi_stop_color_gradient #(
  parameter int MAX_COLORS = msg_pkg::MAX_COLORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,    // [7:0] palette_index
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic [1:0]                        out_tuser,   // [1:0] status
  input  logic                              cfg_we,
  input  logic [msg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SEG_STAGES = 4;
  localparam int DIV_STAGES = msg_pkg::DIV_STAGES;
  localparam int NSTAGE     = SEG_STAGES + 1 + DIV_STAGES;

  // configuration
  logic [msg_pkg::LEN_W-1:0]                       lut_size_r;
  logic [msg_pkg::CNT_W-1:0]                       color_count_r;
  logic [MAX_COLORS-1:0][msg_pkg::COLOR_W-1:0]     colors_r;
  logic [msg_pkg::CFG_IDX_W-1:0]                   color_sel;

  assign color_sel = cfg_index - msg_pkg::REG_COLOR_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_size_r    <= msg_pkg::LEN_W'(256);
      color_count_r <= msg_pkg::CNT_W'(2);
      for (int k = 0; k < MAX_COLORS; k++) begin
        colors_r[k] <= (k == 1) ? '1 : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        msg_pkg::REG_LUT_SIZE:    lut_size_r    <= cfg_data[msg_pkg::LEN_W-1:0];
        msg_pkg::REG_COLOR_COUNT: color_count_r <= cfg_data[msg_pkg::CNT_W-1:0];
        default: begin
          for (int k = 0; k < MAX_COLORS; k++) begin
            if (cfg_index >= msg_pkg::REG_COLOR_0 &&
                color_sel == msg_pkg::CFG_IDX_W'(k)) colors_r[k] <= cfg_data;
          end
        end
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] stage_en;

  always_comb begin
    stage_en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      stage_en[i] = !vld_r[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stage_en[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (stage_en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_tready  = stage_en[0];
  assign out_tvalid = vld_r[NSTAGE-1];

  // datapath
  logic [msg_pkg::LEN_W-1:0]                               wt_to, wt_from, span, den;
  logic [msg_pkg::COLOR_W-1:0]                             c_from, c_to;
  msg_pkg::item_ctl_t                                      seg_ctl;
  logic [msg_pkg::NUM_CH-1:0][msg_pkg::NUM_W-1:0]          num;
  msg_pkg::status_t                                        lerp_status, quo_status;
  logic [msg_pkg::NUM_CH-1:0][msg_pkg::CH_W-1:0]           quo;

  msg_seg #(.MAX_COLORS(MAX_COLORS)) u_seg (
    .clk         (clk),
    .stage_en    (stage_en[SEG_STAGES-1:0]),
    .idx         (in_tdata[msg_pkg::IDX_W-1:0]),
    .lut_size    (lut_size_r),
    .color_count (color_count_r),
    .colors      (colors_r),
    .wt_to       (wt_to),
    .wt_from     (wt_from),
    .span        (span),
    .c_from      (c_from),
    .c_to        (c_to),
    .ctl         (seg_ctl)
  );

  msg_lerp u_lerp (
    .clk      (clk),
    .stage_en (stage_en[SEG_STAGES]),
    .wt_to    (wt_to),
    .wt_from  (wt_from),
    .span     (span),
    .c_from   (c_from),
    .c_to     (c_to),
    .ctl      (seg_ctl),
    .num      (num),
    .den      (den),
    .status   (lerp_status)
  );

  msg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_en   (stage_en[NSTAGE-1:SEG_STAGES+1]),
    .last_vld   (vld_r[NSTAGE-1]),
    .num        (num),
    .den        (den),
    .status     (lerp_status),
    .quo        (quo),
    .quo_status (quo_status)
  );

  // channel 2 of the datapath is red
  assign out_tdata = {quo[0], quo[1], quo[2]};
  assign out_tuser = quo_status;

  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != msg_pkg::STATUS_OK) |-> (out_tdata == '0))
    else $error("error status with non-zero colour");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NSTAGE-1] |-> in_tready)
    else $error("input stalled with empty output stage");

  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == msg_pkg::REG_LUT_SIZE)
      |=> (lut_size_r == $past(cfg_data[msg_pkg::LEN_W-1:0])))
    else $error("lut_size write not taken");

endmodule

// File: rtl/msg_seg.sv
// Segment finder: four pipeline stages from palette index to segment colours
// and interpolation weights. Depends on msg_pkg.
module msg_seg #(
  parameter int MAX_COLORS = msg_pkg::MAX_COLORS_DEF
) (
  input  logic                                           clk,
  input  logic [3:0]                                     stage_en,
  input  logic [msg_pkg::IDX_W-1:0]                      idx,
  input  logic [msg_pkg::LEN_W-1:0]                      lut_size,
  input  logic [msg_pkg::CNT_W-1:0]                      color_count,
  input  logic [MAX_COLORS-1:0][msg_pkg::COLOR_W-1:0]    colors,
  output logic [msg_pkg::LEN_W-1:0]                      wt_to,
  output logic [msg_pkg::LEN_W-1:0]                      wt_from,
  output logic [msg_pkg::LEN_W-1:0]                      span,
  output logic [msg_pkg::COLOR_W-1:0]                    c_from,
  output logic [msg_pkg::COLOR_W-1:0]                    c_to,
  output msg_pkg::item_ctl_t                             ctl
);

  localparam int NB    = MAX_COLORS - 1;
  localparam int SEG_W = $clog2(MAX_COLORS);
  localparam int KQ_W  = msg_pkg::LEN_W + msg_pkg::CNT_W;

  // len / n for n = 1..5 by reciprocal multiply, exact for len below 512
  function automatic logic [msg_pkg::LEN_W-1:0] div_small(
    input logic [msg_pkg::LEN_W-1:0] len,
    input logic [msg_pkg::CNT_W-1:0] n
  );
    logic [msg_pkg::LEN_W+8:0] p3;
    logic [msg_pkg::LEN_W+8:0] p5;
    p3 = {9'd0, len} * 18'd171;
    p5 = {9'd0, len} * 18'd205;
    unique case (n)
      3'd1:    div_small = len;
      3'd2:    div_small = len >> 1;
      3'd3:    div_small = p3[msg_pkg::LEN_W+8:9];
      3'd4:    div_small = len >> 2;
      3'd5:    div_small = {1'b0, p5[msg_pkg::LEN_W+8:10]};
      default: div_small = len;
    endcase
  endfunction

  // stage A: clamps, error checks, base segment size
  logic [msg_pkg::IDX_W-1:0] idx_a_r;
  logic [msg_pkg::LEN_W-1:0] len_a_r, len_a_nxt, q_a_r, q_a_nxt;
  logic [msg_pkg::CNT_W-1:0] nseg_a_r, nseg_a_nxt, m_a;
  msg_pkg::item_ctl_t        ctl_a_r, ctl_a_nxt;

  always_comb begin
    if (color_count < 3'd2)                  m_a = 3'd2;
    else if (32'(color_count) > MAX_COLORS)  m_a = msg_pkg::CNT_W'(MAX_COLORS);
    else                                     m_a = color_count;
    nseg_a_nxt = m_a - 3'd1;
    if (32'(lut_size) > msg_pkg::LUT_DEPTH) len_a_nxt = msg_pkg::LEN_W'(msg_pkg::LUT_DEPTH);
    else                                    len_a_nxt = lut_size;
    ctl_a_nxt.pass_end = 1'b0;
    if (len_a_nxt < msg_pkg::LEN_W'(nseg_a_nxt))     ctl_a_nxt.status = msg_pkg::STATUS_SHORT;
    else if ({1'b0, idx} >= len_a_nxt)                ctl_a_nxt.status = msg_pkg::STATUS_RANGE;
    else                                              ctl_a_nxt.status = msg_pkg::STATUS_OK;
    q_a_nxt = div_small(len_a_nxt, nseg_a_nxt);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      idx_a_r  <= idx;
      len_a_r  <= len_a_nxt;
      nseg_a_r <= nseg_a_nxt;
      q_a_r    <= q_a_nxt;
      ctl_a_r  <= ctl_a_nxt;
    end
  end

  // stage B: remainder and multiples of the base size
  logic [msg_pkg::IDX_W-1:0]     idx_b_r;
  logic [msg_pkg::CNT_W-1:0]     nseg_b_r, r_b_r, r_b_nxt;
  logic [NB-1:0][KQ_W-1:0]       kq_b_r, kq_b_nxt;
  logic [KQ_W-1:0]               nq_b;
  msg_pkg::item_ctl_t            ctl_b_r;

  always_comb begin
    nq_b    = KQ_W'(nseg_a_r) * KQ_W'(q_a_r);
    r_b_nxt = msg_pkg::CNT_W'(KQ_W'(len_a_r) - nq_b);
    for (int k = 0; k < NB; k++) begin
      kq_b_nxt[k] = KQ_W'(q_a_r) * KQ_W'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      idx_b_r  <= idx_a_r;
      nseg_b_r <= nseg_a_r;
      r_b_r    <= r_b_nxt;
      kq_b_r   <= kq_b_nxt;
      ctl_b_r  <= ctl_a_r;
    end
  end

  // stage C: segment boundaries; the first r segments are one entry longer
  logic [msg_pkg::IDX_W-1:0]     idx_c_r;
  logic [NB-1:0][KQ_W-1:0]       bnd_c_r, bnd_c_nxt;
  logic [NB-1:0]                 ge_c_r, ge_c_nxt;
  msg_pkg::item_ctl_t            ctl_c_r;

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      bnd_c_nxt[k] = kq_b_r[k] +
                     KQ_W'((r_b_r > msg_pkg::CNT_W'(k + 1)) ? msg_pkg::CNT_W'(k + 1) : r_b_r);
      // the last boundary is the gradient end, never passed by a valid index
      ge_c_nxt[k]  = (KQ_W'(idx_b_r) >= bnd_c_nxt[k]) && (32'(nseg_b_r) > k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      idx_c_r <= idx_b_r;
      bnd_c_r <= bnd_c_nxt;
      ge_c_r  <= ge_c_nxt;
      ctl_c_r <= ctl_b_r;
    end
  end

  // stage D: pick segment, offsets into it, end colours
  logic [SEG_W-1:0]             seg_d;
  logic [msg_pkg::LEN_W-1:0]    start_d, next_d, size_d;
  logic [msg_pkg::COLOR_W-1:0]  c_from_d, c_to_d;
  logic [msg_pkg::LEN_W-1:0]    wt_to_r, wt_from_r, span_r;
  logic [msg_pkg::COLOR_W-1:0]  c_from_r, c_to_r;
  msg_pkg::item_ctl_t           ctl_d_r, ctl_d_nxt;

  always_comb begin
    seg_d = '0;
    for (int k = 0; k < NB; k++) begin
      if (ge_c_r[k]) seg_d = SEG_W'(k + 1);
    end
    start_d  = '0;
    next_d   = '0;
    c_from_d = '0;
    c_to_d   = '0;
    for (int k = 0; k < NB; k++) begin
      if (seg_d == SEG_W'(k)) begin
        next_d   = bnd_c_r[k][msg_pkg::LEN_W-1:0];
        c_from_d = colors[k];
        c_to_d   = colors[k+1];
      end
    end
    for (int k = 1; k < NB; k++) begin
      if (seg_d == SEG_W'(k)) start_d = bnd_c_r[k-1][msg_pkg::LEN_W-1:0];
    end
    size_d             = next_d - start_d;
    ctl_d_nxt.status   = ctl_c_r.status;
    ctl_d_nxt.pass_end = (size_d <= msg_pkg::LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      wt_to_r   <= {1'b0, idx_c_r} - start_d;
      wt_from_r <= next_d - msg_pkg::LEN_W'(1) - {1'b0, idx_c_r};
      span_r    <= size_d - msg_pkg::LEN_W'(1);
      c_from_r  <= c_from_d;
      c_to_r    <= c_to_d;
      ctl_d_r   <= ctl_d_nxt;
    end
  end

  assign wt_to   = wt_to_r;
  assign wt_from = wt_from_r;
  assign span    = span_r;
  assign c_from  = c_from_r;
  assign c_to    = c_to_r;
  assign ctl     = ctl_d_r;

endmodule

// File: rtl/msg_lerp.sv
// Weighting stage: per channel c_from*wt_from + c_to*wt_to, plus the divisor.
// Error items and one-entry segments are folded in as divide-by-one. Uses msg_pkg.
module msg_lerp (
  input  logic                                               clk,
  input  logic                                               stage_en,
  input  logic [msg_pkg::LEN_W-1:0]                          wt_to,
  input  logic [msg_pkg::LEN_W-1:0]                          wt_from,
  input  logic [msg_pkg::LEN_W-1:0]                          span,
  input  logic [msg_pkg::COLOR_W-1:0]                        c_from,
  input  logic [msg_pkg::COLOR_W-1:0]                        c_to,
  input  msg_pkg::item_ctl_t                                 ctl,
  output logic [msg_pkg::NUM_CH-1:0][msg_pkg::NUM_W-1:0]     num,
  output logic [msg_pkg::LEN_W-1:0]                          den,
  output msg_pkg::status_t                                   status
);

  logic [msg_pkg::NUM_CH-1:0][msg_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [msg_pkg::LEN_W-1:0]                      den_r, den_nxt;
  msg_pkg::status_t                               status_r;
  logic [msg_pkg::CH_W-1:0]                       ca, cb;

  // channel 0 is blue (bits 7:0), channel 2 red
  always_comb begin
    for (int ch = 0; ch < msg_pkg::NUM_CH; ch++) begin
      ca = c_from[ch*msg_pkg::CH_W +: msg_pkg::CH_W];
      cb = c_to[ch*msg_pkg::CH_W +: msg_pkg::CH_W];
      if (ctl.status != msg_pkg::STATUS_OK) begin
        num_nxt[ch] = '0;
      end else if (ctl.pass_end) begin
        num_nxt[ch] = msg_pkg::NUM_W'(cb);
      end else begin
        num_nxt[ch] = msg_pkg::NUM_W'(ca) * msg_pkg::NUM_W'(wt_from) +
                      msg_pkg::NUM_W'(cb) * msg_pkg::NUM_W'(wt_to);
      end
    end
    if (ctl.status != msg_pkg::STATUS_OK || ctl.pass_end) den_nxt = msg_pkg::LEN_W'(1);
    else                                                   den_nxt = span;
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      status_r <= ctl.status;
    end
  end

  assign num    = num_r;
  assign den    = den_r;
  assign status = status_r;

endmodule

// File: rtl/msg_div.sv
// Pipelined restoring divider, three channels in lockstep, two quotient bits
// per stage. Depends on msg_pkg.
module msg_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic [msg_pkg::DIV_STAGES-1:0]                     stage_en,
  input  logic                                               last_vld,
  input  logic [msg_pkg::NUM_CH-1:0][msg_pkg::NUM_W-1:0]     num,
  input  logic [msg_pkg::LEN_W-1:0]                          den,
  input  msg_pkg::status_t                                   status,
  output logic [msg_pkg::NUM_CH-1:0][msg_pkg::CH_W-1:0]      quo,
  output msg_pkg::status_t                                   quo_status
);

  localparam int STEP       = msg_pkg::DIV_STEP;
  localparam int DIV_STAGES = msg_pkg::DIV_STAGES;
  localparam int BP_W       = $clog2(msg_pkg::CH_W);

  logic [DIV_STAGES-1:0][msg_pkg::NUM_CH-1:0][msg_pkg::NUM_W-1:0] rem_r, rem_in, rem_nxt;
  logic [DIV_STAGES-1:0][msg_pkg::NUM_CH-1:0][msg_pkg::CH_W-1:0]  quo_r, quo_in, quo_nxt;
  logic [DIV_STAGES-1:0][msg_pkg::LEN_W-1:0]                      den_r, den_in;
  msg_pkg::status_t                                               status_r [DIV_STAGES];
  msg_pkg::status_t                                               status_in [DIV_STAGES];

  for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
    if (gs == 0) begin : g_head
      assign rem_in[gs]    = num;
      assign quo_in[gs]    = '0;
      assign den_in[gs]    = den;
      assign status_in[gs] = status;
    end else begin : g_body
      assign rem_in[gs]    = rem_r[gs-1];
      assign quo_in[gs]    = quo_r[gs-1];
      assign den_in[gs]    = den_r[gs-1];
      assign status_in[gs] = status_r[gs-1];
    end

    always_comb begin
      int bp;
      logic [msg_pkg::NUM_W-1:0] trial;
      rem_nxt[gs] = rem_in[gs];
      quo_nxt[gs] = quo_in[gs];
      for (int ch = 0; ch < msg_pkg::NUM_CH; ch++) begin
        for (int b = 0; b < STEP; b++) begin
          bp    = msg_pkg::CH_W - 1 - (gs * STEP + b);
          trial = msg_pkg::NUM_W'(den_in[gs]) << bp;
          if (rem_nxt[gs][ch] >= trial) begin
            rem_nxt[gs][ch]               = rem_nxt[gs][ch] - trial;
            quo_nxt[gs][ch][BP_W'(bp)]    = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[gs]) begin
        rem_r[gs]    <= rem_nxt[gs];
        quo_r[gs]    <= quo_nxt[gs];
        den_r[gs]    <= den_in[gs];
        status_r[gs] <= status_in[gs];
      end
    end
  end

  assign quo        = quo_r[DIV_STAGES-1];
  assign quo_status = status_r[DIV_STAGES-1];

  // the weighted sum is below 256*den, so the remainder must end below den
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    last_vld |-> (rem_r[DIV_STAGES-1][0] < msg_pkg::NUM_W'(den_r[DIV_STAGES-1])) &&
                 (rem_r[DIV_STAGES-1][1] < msg_pkg::NUM_W'(den_r[DIV_STAGES-1])) &&
                 (rem_r[DIV_STAGES-1][2] < msg_pkg::NUM_W'(den_r[DIV_STAGES-1])))
    else $error("divider remainder not below divisor");

endmodule
